@@ hdl/eab_pkg.sv @@
// Shared types and fixed-point constants for the Euler angle basis vector pipeline.
package eab_pkg;

  typedef struct packed {
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] roll_angle;
  } in_t;

  typedef struct packed {
    logic signed [15:0] forward_x;
    logic signed [15:0] forward_y;
    logic signed [15:0] forward_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } out_t;

  // sine/cosine work in unsigned Q30
  localparam int QB = 30;
  localparam logic [30:0] QONE = 31'h4000_0000;
  localparam logic [30:0] HALF_PI = 31'd1686629713;
  localparam logic [61:0] RND_Q = 62'h2000_0000;

  // Horner steps of the series; the last sine step is the multiply by t
  localparam int NSTEP = 6;
  localparam logic [7:0] SIN_D [NSTEP] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6, 8'd1};
  localparam logic [7:0] COS_D [NSTEP] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [32:0] SIN_M [NSTEP] = '{
    33'(64'd4294967296 / 110), 33'(64'd4294967296 / 72), 33'(64'd4294967296 / 42),
    33'(64'd4294967296 / 20), 33'(64'd4294967296 / 6), 33'(64'd4294967296)
  };
  localparam logic [32:0] COS_M [NSTEP] = '{
    33'(64'd4294967296 / 132), 33'(64'd4294967296 / 90), 33'(64'd4294967296 / 56),
    33'(64'd4294967296 / 30), 33'(64'd4294967296 / 12), 33'(64'd4294967296 / 2)
  };

  typedef struct packed {
    logic [29:0] t;
    logic [29:0] t2;
    logic [1:0]  quad;
    logic        swap;
  } side_t;

endpackage

@@ hdl/euler_angles_to_basis_vectors.sv @@
// Top level: pipelined Euler angles to forward, right and up basis vectors.
//
//  channel | direction | payload        | handshake
//  input   | in        | in_i  (in_t)   | valid_i / stall_o
//  output  | out       | out_o (out_t)  | valid_o / stall_i
//
// One transaction per cycle when the output does not stall, through a fixed pipeline:
// 5 stages of angle folding, 24 stages of series evaluation (four per Horner
// step: multiply, round, reciprocal multiply, correction), quadrant fix, two
// product levels of two stages each, a sum stage and the output stage.
// Reset clears the valid bits only. A stall on a pending output freezes the
// whole pipeline in place, and stall_o follows it in the same cycle.
module euler_angles_to_basis_vectors #(
  parameter int ANGLE_BITS    = 16,
  parameter int FRACTION_BITS = 14
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          stall_o,
  input  eab_pkg::in_t  in_i,
  output logic          valid_o,
  input  logic          stall_i,
  output eab_pkg::out_t out_o
);
  import eab_pkg::*;

  localparam int TAY0  = 5;
  localparam int NSIDE = TAY0 + 4 * NSTEP;
  localparam int NLAT  = NSIDE + 7;
  localparam int SH    = QB - FRACTION_BITS;
  localparam logic [33:0] RND_F = (34'(1) << SH) >> 1;
  localparam logic [33:0] LIM   = 34'(1) << FRACTION_BITS;

  // first-level product operands: angle (0 pitch, 1 yaw, 2 roll), 1 = sine
  localparam int L1_AA [10] = '{2, 2, 0, 0, 2, 2, 2, 2, 2, 2};
  localparam int L1_AS [10] = '{1, 0, 0, 0, 1, 0, 0, 0, 1, 1};
  localparam int L1_BA [10] = '{0, 0, 1, 1, 0, 0, 1, 1, 1, 1};
  localparam int L1_BS [10] = '{1, 1, 0, 1, 0, 0, 1, 0, 1, 0};

  function automatic logic [30:0] rnd30(input logic [61:0] p);
    logic [61:0] s;
    s = (p + RND_Q) >> QB;
    return s[30:0];
  endfunction

  // reciprocal estimate is exact or one low; one compare fixes it
  function automatic logic [30:0] div_fix(input logic [30:0] m, input logic [63:0] x,
                                          input logic [7:0] d);
    logic [30:0] q0;
    logic [31:0] rem;
    q0  = x[62:32];
    rem = {1'b0, m} - 32'(q0) * 32'(d);
    return (rem >= 32'(d)) ? q0 + 31'd1 : q0;
  endfunction

  function automatic logic signed [33:0] sv(input logic [30:0] m, input logic n);
    return n ? -$signed(34'(m)) : $signed(34'(m));
  endfunction

  function automatic logic [15:0] to_field(input logic signed [33:0] q);
    logic        neg;
    logic [33:0] m;
    logic [33:0] r;
    neg = q[33];
    m   = neg ? 34'(-q) : 34'(q);
    m   = (m + RND_F) >> SH;
    if (m > LIM) m = LIM;
    r = neg ? 34'(0) - m : m;
    return r[15:0];
  endfunction

  logic              en;
  logic [NLAT-1:0]   vld_q;
  logic signed [15:0] raw [3];

  side_t       side_q [3][NSIDE];
  side_t       side_d [3];
  logic [29:0] tr_q [3];
  logic [29:0] tr_d [3];
  logic [60:0] tp_q [3];
  logic [59:0] t2p_q [3];

  logic [61:0] sprod_q [3][NSTEP];
  logic [30:0] smid_q  [3][NSTEP];
  logic [63:0] sx_q    [3][NSTEP];
  logic [30:0] sh_q    [3][NSTEP];
  logic [61:0] cprod_q [3][NSTEP];
  logic [30:0] cmid_q  [3][NSTEP];
  logic [63:0] cx_q    [3][NSTEP];
  logic [30:0] ch_q    [3][NSTEP];

  logic [30:0] smag_q [3];
  logic        sneg_q [3];
  logic [30:0] cmag_q [3];
  logic        cneg_q [3];

  logic [61:0] prod1_q [10];
  logic        neg1_q  [10];
  logic [30:0] r1_q    [10];
  logic        n1_q    [10];
  logic [30:0] r1c_q   [10];
  logic        n1c_q   [10];
  logic [30:0] r1d_q   [10];
  logic        n1d_q   [10];
  logic [61:0] prod2_q [4];
  logic        neg2_q  [4];
  logic [30:0] r2_q    [4];
  logic        n2_q    [4];
  // sp, cy, sy carried through the product levels
  logic [30:0] keep_m_q [4][3];
  logic        keep_n_q [4][3];

  logic signed [33:0] sum_q [9];
  logic signed [33:0] sum_d [9];
  out_t out_q;

  assign en      = !(vld_q[NLAT-1] && stall_i);
  assign stall_o = vld_q[NLAT-1] && stall_i;
  assign valid_o = vld_q[NLAT-1];
  assign out_o   = out_q;

  assign raw[0] = in_i.pitch_angle;
  assign raw[1] = in_i.yaw_angle;
  assign raw[2] = in_i.roll_angle;

  always_comb begin
    logic [31:0] u;
    for (int a = 0; a < 3; a++) begin
      u = 32'($signed(raw[a])) << (32 - ANGLE_BITS);
      side_d[a].quad = u[31:30];
      side_d[a].swap = u[29:0] > 30'h2000_0000;
      side_d[a].t    = '0;
      side_d[a].t2   = '0;
      tr_d[a] = side_d[a].swap ? 30'(QONE - 31'(u[29:0])) : u[29:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NLAT-2:0], valid_i};
    end
  end

  // angle folding and series evaluation
  always_ff @(posedge clk_i) begin
    logic [29:0] mul_s;
    logic [30:0] hin_s;
    logic [30:0] hin_c;
    logic [30:0] q;
    logic [61:0] tmp;
    side_t       nxt;
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        side_q[a][0] <= side_d[a];
        tr_q[a]      <= tr_d[a];
        // t joins the side data at stage 2, t squared at stage 4
        for (int j = 1; j < NSIDE; j++) begin
          nxt = side_q[a][j-1];
          if (j == 2) begin
            tmp   = (62'(tp_q[a]) + RND_Q) >> QB;
            nxt.t = tmp[29:0];
          end
          if (j == 4) begin
            tmp    = (62'(t2p_q[a]) + RND_Q) >> QB;
            nxt.t2 = tmp[29:0];
          end
          side_q[a][j] <= nxt;
        end
        tp_q[a] <= 61'(tr_q[a]) * 61'(HALF_PI);
        t2p_q[a] <= 60'(side_q[a][2].t) * 60'(side_q[a][2].t);
        for (int k = 0; k < NSTEP; k++) begin
          mul_s = (k == NSTEP - 1) ? side_q[a][TAY0-1+4*k].t : side_q[a][TAY0-1+4*k].t2;
          hin_s = (k == 0) ? QONE : sh_q[a][k-1];
          hin_c = (k == 0) ? QONE : ch_q[a][k-1];
          sprod_q[a][k] <= 62'(mul_s) * 62'(hin_s);
          cprod_q[a][k] <= 62'(side_q[a][TAY0-1+4*k].t2) * 62'(hin_c);
          smid_q[a][k]  <= rnd30(sprod_q[a][k]);
          cmid_q[a][k]  <= rnd30(cprod_q[a][k]);
          sx_q[a][k]    <= 64'(smid_q[a][k]) * 64'(SIN_M[k]);
          cx_q[a][k]    <= 64'(cmid_q[a][k]) * 64'(COS_M[k]);
          q = div_fix(smid_q[a][k], sx_q[a][k], SIN_D[k]);
          sh_q[a][k] <= (k == NSTEP - 1) ? q : QONE - q;
          ch_q[a][k] <= QONE - div_fix(cmid_q[a][k], cx_q[a][k], COS_D[k]);
        end
      end
    end
  end

  // octant swap and quadrant signs, then the product tree, sum and output registers
  always_ff @(posedge clk_i) begin
    logic [30:0] s;
    logic [30:0] c;
    logic [30:0] ma;
    logic [30:0] mb;
    logic        na;
    logic        nb;
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        s = side_q[a][NSIDE-1].swap ? ch_q[a][NSTEP-1] : sh_q[a][NSTEP-1];
        c = side_q[a][NSIDE-1].swap ? sh_q[a][NSTEP-1] : ch_q[a][NSTEP-1];
        case (side_q[a][NSIDE-1].quad)
          2'd0: begin
            smag_q[a] <= s; sneg_q[a] <= 1'b0; cmag_q[a] <= c; cneg_q[a] <= 1'b0;
          end
          2'd1: begin
            smag_q[a] <= c; sneg_q[a] <= 1'b0; cmag_q[a] <= s; cneg_q[a] <= 1'b1;
          end
          2'd2: begin
            smag_q[a] <= s; sneg_q[a] <= 1'b1; cmag_q[a] <= c; cneg_q[a] <= 1'b1;
          end
          default: begin
            smag_q[a] <= c; sneg_q[a] <= 1'b1; cmag_q[a] <= s; cneg_q[a] <= 1'b0;
          end
        endcase
      end
      for (int i = 0; i < 10; i++) begin
        ma = (L1_AS[i] == 1) ? smag_q[L1_AA[i]] : cmag_q[L1_AA[i]];
        na = (L1_AS[i] == 1) ? sneg_q[L1_AA[i]] : cneg_q[L1_AA[i]];
        mb = (L1_BS[i] == 1) ? smag_q[L1_BA[i]] : cmag_q[L1_BA[i]];
        nb = (L1_BS[i] == 1) ? sneg_q[L1_BA[i]] : cneg_q[L1_BA[i]];
        prod1_q[i] <= 62'(ma) * 62'(mb);
        neg1_q[i]  <= na ^ nb;
        r1_q[i]    <= rnd30(prod1_q[i]);
        n1_q[i]    <= neg1_q[i];
        r1c_q[i]   <= r1_q[i];
        n1c_q[i]   <= n1_q[i];
        r1d_q[i]   <= r1c_q[i];
        n1d_q[i]   <= n1c_q[i];
      end
      keep_m_q[0][0] <= smag_q[0]; keep_n_q[0][0] <= sneg_q[0];
      keep_m_q[0][1] <= cmag_q[1]; keep_n_q[0][1] <= cneg_q[1];
      keep_m_q[0][2] <= smag_q[1]; keep_n_q[0][2] <= sneg_q[1];
      for (int j = 1; j < 4; j++) begin
        keep_m_q[j] <= keep_m_q[j-1];
        keep_n_q[j] <= keep_n_q[j-1];
      end
      for (int i = 0; i < 4; i++) begin
        prod2_q[i] <= 62'(r1_q[i/2]) * 62'(keep_m_q[1][1 + i%2]);
        neg2_q[i]  <= n1_q[i/2] ^ keep_n_q[1][1 + i%2];
        r2_q[i]    <= rnd30(prod2_q[i]);
        n2_q[i]    <= neg2_q[i];
      end
      sum_q <= sum_d;
      out_q.forward_x <= to_field(sum_q[0]);
      out_q.forward_y <= to_field(sum_q[1]);
      out_q.forward_z <= to_field(sum_q[2]);
      out_q.right_x   <= to_field(sum_q[3]);
      out_q.right_y   <= to_field(sum_q[4]);
      out_q.right_z   <= to_field(sum_q[5]);
      out_q.up_x      <= to_field(sum_q[6]);
      out_q.up_y      <= to_field(sum_q[7]);
      out_q.up_z      <= to_field(sum_q[8]);
    end
  end

  always_comb begin
    sum_d[0] = sv(r1d_q[2], n1d_q[2]);
    sum_d[1] = sv(r1d_q[3], n1d_q[3]);
    sum_d[2] = -sv(keep_m_q[3][0], keep_n_q[3][0]);
    sum_d[3] = sv(r1d_q[6], n1d_q[6]) - sv(r2_q[0], n2_q[0]);
    sum_d[4] = -sv(r2_q[1], n2_q[1]) - sv(r1d_q[7], n1d_q[7]);
    sum_d[5] = -sv(r1d_q[4], n1d_q[4]);
    sum_d[6] = sv(r2_q[2], n2_q[2]) + sv(r1d_q[8], n1d_q[8]);
    sum_d[7] = sv(r2_q[3], n2_q[3]) - sv(r1d_q[9], n1d_q[9]);
    sum_d[8] = sv(r1d_q[5], n1d_q[5]);
  end

`ifndef NO_ASSERTIONS
  a_stall_only_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !stall_o) else $error("stall raised with no result pending");

  a_accept_enters_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> vld_q[0]) else $error("accepted transaction lost at entry");

  a_frozen_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |=> $stable(vld_q)) else $error("pipeline moved during stall");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (FRACTION_BITS > 14) ||
      ($signed(out_o.up_z) <= 16'sd16384 && $signed(out_o.up_z) >= -16'sd16384))
    else $error("component beyond unit range");
`endif

endmodule

@@ verif/euler_angles_to_basis_vectors_tb.sv @@
// Testbench for the Euler angle to basis vector pipeline: directed and random angles.
`timescale 1ns / 100ps

module euler_angles_to_basis_vectors_tb;
  import eab_pkg::*;

  localparam longint unsigned QONE_L = 64'd1 << 30;
  localparam longint unsigned RND_L = 64'd1 << 29;
  localparam longint unsigned HALF_PI_L = 64'd1686629713;
  localparam int OUT_FRAC = 14;
  localparam int LATENCY = 36;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_o;
  in_t in_i = '0;
  logic valid_o;
  logic stall_i = 1'b0;
  out_t out_o;

  euler_angles_to_basis_vectors uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .stall_o(stall_o), .in_i(in_i),
    .valid_o(valid_o), .stall_i(stall_i), .out_o(out_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  in_t angle_queue[$];
  out_t vector_queue[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int long_hold_req = 0;
  int hold_left = 0;
  int errors = 0;
  int checked = 0;
  logic in_taken = 1'b0;

  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b + RND_L) >> 30;
  endfunction

  function automatic longint signed qmul_s(longint signed a, longint signed b);
    longint unsigned m;
    m = qmul(a < 0 ? -a : a, b < 0 ? -b : b);
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  // series sine/cosine of a folded angle, then quadrant sign fix
  function automatic void angle_trig(input logic [15:0] raw, output longint signed sn,
                                     output longint signed cs);
    longint unsigned r, tr, t, t2, h, s, c, k;
    logic [1:0] quad;
    int sdiv[5];
    int cdiv[5];
    sdiv = '{110, 72, 42, 20, 6};
    cdiv = '{132, 90, 56, 30, 12};
    quad = raw[15:14];
    r = longint'(raw[13:0]) << 16;
    tr = (r > (QONE_L >> 1)) ? QONE_L - r : r;
    t = (tr * HALF_PI_L + RND_L) >> 30;
    t2 = qmul(t, t);
    h = QONE_L;
    for (int i = 0; i < 5; i++) h = QONE_L - qmul(t2, h) / sdiv[i];
    s = qmul(t, h);
    h = QONE_L;
    for (int i = 0; i < 5; i++) h = QONE_L - qmul(t2, h) / cdiv[i];
    c = QONE_L - qmul(t2, h) / 2;
    if (r > (QONE_L >> 1)) begin
      k = s; s = c; c = k;
    end
    case (quad)
      2'd0: begin sn = s; cs = c; end
      2'd1: begin sn = c; cs = -longint'(s); end
      2'd2: begin sn = -longint'(s); cs = -longint'(c); end
      default: begin sn = -longint'(c); cs = s; end
    endcase
  endfunction

  function automatic logic [15:0] to_q14(longint signed q);
    longint unsigned m;
    m = q < 0 ? -q : q;
    m = (m + (64'd1 << (29 - OUT_FRAC))) >> (30 - OUT_FRAC);
    if (m > (64'd1 << OUT_FRAC)) m = 64'd1 << OUT_FRAC;
    return q < 0 ? 16'(-m) : 16'(m);
  endfunction

  function automatic out_t basis_vectors(in_t a);
    longint signed sp, cp, sy, cy, sr, cr, srsp, crsp;
    out_t o;
    angle_trig(a.pitch_angle, sp, cp);
    angle_trig(a.yaw_angle, sy, cy);
    angle_trig(a.roll_angle, sr, cr);
    srsp = qmul_s(sr, sp);
    crsp = qmul_s(cr, sp);
    o.forward_x = to_q14(qmul_s(cp, cy));
    o.forward_y = to_q14(qmul_s(cp, sy));
    o.forward_z = to_q14(-sp);
    o.right_x = to_q14(-qmul_s(srsp, cy) + qmul_s(cr, sy));
    o.right_y = to_q14(-qmul_s(srsp, sy) - qmul_s(cr, cy));
    o.right_z = to_q14(-qmul_s(sr, cp));
    o.up_x = to_q14(qmul_s(crsp, cy) + qmul_s(sr, sy));
    o.up_y = to_q14(qmul_s(crsp, sy) - qmul_s(sr, cy));
    o.up_z = to_q14(qmul_s(cr, cp));
    return o;
  endfunction

  // driver: hold the payload until the transaction is taken
  always @(negedge clk_i) begin
    if (rst_ni && !(valid_i && !in_taken)) begin
      if (angle_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_i <= angle_queue.pop_front();
        valid_i <= 1'b1;
      end else begin
        valid_i <= 1'b0;
      end
    end
  end

  // receiver stall, with a single long hold-off
  always @(negedge clk_i) begin
    if (long_hold_req > 0 && hold_left == 0) begin
      hold_left <= long_hold_req;
      long_hold_req <= 0;
      stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      stall_i <= 1'b1;
    end else begin
      stall_i <= $urandom_range(99) < recv_stall_pct;
    end
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk_i) begin
    out_t want;
    string names[9];
    names = '{"forward_x", "forward_y", "forward_z", "right_x", "right_y", "right_z",
              "up_x", "up_y", "up_z"};
    in_taken <= valid_i && !stall_o;
    if (rst_ni && valid_i && !stall_o) vector_queue = {vector_queue, basis_vectors(in_i)};
    if (rst_ni && valid_o && !stall_i) begin
      checked <= checked + 1;
      if (vector_queue.size() == 0) begin
        errors = errors + 1;
        if (errors <= 10) $display("unexpected output transaction %h", out_o);
      end else begin
        want = vector_queue.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (want[143 - 16 * i -: 16] !== out_o[143 - 16 * i -: 16]) begin
            errors = errors + 1;
            if (errors <= 10)
              $display("%s mismatch: expected %0d got %0d", names[i],
                       $signed(want[143 - 16 * i -: 16]), $signed(out_o[143 - 16 * i -: 16]));
          end
        end
      end
    end
  end

  function automatic logic [15:0] pick_angle();
    logic [15:0] corner[12];
    corner = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF, 16'hFFFF, 16'h0001,
               16'h2000, 16'h2001, 16'h1FFF, 16'h6000, 16'hE000};
    if ($urandom_range(9) == 0) return corner[$urandom_range(11)];
    return 16'($urandom);
  endfunction

  initial begin
    in_t a;
    logic [15:0] dirs[8];
    dirs = '{16'h0000, 16'h4000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h2000, 16'h2001, 16'hA000};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      a.pitch_angle = dirs[i];
      a.yaw_angle = dirs[(i + 3) % 8];
      a.roll_angle = dirs[(i + 5) % 8];
      angle_queue = {angle_queue, a};
      a = {dirs[i], dirs[i], dirs[i]};
      angle_queue = {angle_queue, a};
    end
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 62; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 62; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      for (int i = 0; i < 167; i++) begin
        a.pitch_angle = pick_angle();
        a.yaw_angle = pick_angle();
        a.roll_angle = pick_angle();
        angle_queue = {angle_queue, a};
      end
      if (ph == 0) long_hold_req = 300;
      if (ph == 4) begin
        // let everything drain before offering more
        wait (angle_queue.size() == 0 && !valid_i && vector_queue.size() == 0);
      end else begin
        wait (angle_queue.size() == 0);
      end
    end
    wait (angle_queue.size() == 0 && !valid_i);
    recv_stall_pct = 0;
    wait (vector_queue.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("Checked %0d basis vector results over folded, octant-edge and random angles,",
             checked);
    $display("with sender gaps, receiver stalls and a long output hold-off.");
    if (errors == 0 && vector_queue.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
